// ----- rtl/status_led_blink_code_sequencer_assert.svh -----
// Assertion macros used by the status LED blink-code sequencer core (slbcs_core).
`ifndef STATUS_LED_BLINK_CODE_SEQUENCER_ASSERT_SVH
`define STATUS_LED_BLINK_CODE_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/slbcs_pkg.sv -----
// Types, codes, timing constants and lookup tables of the blink-code sequencer.
package slbcs_pkg;

    typedef logic [23:0] t_rgb;
    typedef logic [9:0]  t_ms;
    typedef logic [2:0]  t_stage;
    typedef logic [3:0]  t_code;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SET_MODE    = 2'd1,
        OP_SET_ERROR   = 2'd2,
        OP_CLEAR_ERROR = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode opcode;
        t_code   mode_code;
        t_code   error_code;
    } t_item;

    localparam t_rgb C_RED     = 24'hFF0000;
    localparam t_rgb C_YELLOW  = 24'hFFFF00;
    localparam t_rgb C_MAGENTA = 24'hFF00FF;
    localparam t_rgb C_ORANGE  = 24'hFF6400;
    localparam t_rgb C_BLUE    = 24'h0000FF;
    localparam t_rgb C_CYAN    = 24'h00FFFF;
    localparam t_rgb C_GREEN   = 24'h00FF00;
    localparam t_rgb C_OFF     = 24'h000000;

    localparam t_ms MS_PULSE_ON  = 10'd200;
    localparam t_ms MS_PULSE_OFF = 10'd150;
    localparam t_ms MS_GAP       = 10'd400;
    localparam t_ms MS_TAIL      = 10'd600;
    localparam t_ms MS_MEM_TAIL  = 10'd1000;
    localparam t_ms MS_SOLID     = 10'd200;
    localparam t_ms MS_HOLD      = 10'd100;
    localparam t_ms MS_BLINK_SLOW = 10'd500;
    localparam t_ms MS_BLINK_FAST = 10'd400;
    localparam t_ms MS_NONE      = 10'd0;

    localparam logic [2:0] PREFIX_PULSES = 3'd3;

    localparam t_stage STG_START    = 3'd0;
    localparam t_stage STG_ON       = 3'd1;
    localparam t_stage STG_OFF      = 3'd2;
    localparam t_stage STG_PFX_ON   = 3'd1;
    localparam t_stage STG_PFX_OFF  = 3'd2;
    localparam t_stage STG_GAP      = 3'd3;
    localparam t_stage STG_CODE_ON  = 3'd4;
    localparam t_stage STG_CODE_OFF = 3'd5;
    localparam t_stage STG_TAIL     = 3'd6;

    localparam t_code MODE_BOOT       = 4'd0;
    localparam t_code MODE_USB_WAIT   = 4'd1;
    localparam t_code MODE_USB_OK     = 4'd2;
    localparam t_code MODE_WIFI_CONN  = 4'd3;
    localparam t_code MODE_HTTP_CHECK = 4'd4;
    localparam t_code MODE_MQTT_CONN  = 4'd5;
    localparam t_code MODE_ONLINE     = 4'd6;
    localparam t_code MODE_BLE_SCAN   = 4'd7;
    localparam t_code MODE_BLE_CONN   = 4'd8;

    localparam t_code ERR_NONE           = 4'd0;
    localparam t_code ERR_HTTP           = 4'd1;
    localparam t_code ERR_MQTT_INIT      = 4'd2;
    localparam t_code ERR_MQTT_TRANSPORT = 4'd3;
    localparam t_code ERR_MQTT_CONNECT   = 4'd4;
    localparam t_code ERR_MQTT_PUBLISH   = 4'd5;
    localparam t_code ERR_WIFI           = 4'd6;
    localparam t_code ERR_BLE_SCAN       = 4'd7;
    localparam t_code ERR_BLE_CONNECT    = 4'd8;
    localparam t_code ERR_BLE_SEND       = 4'd9;
    localparam t_code ERR_NVS_SAVE       = 4'd10;
    localparam t_code ERR_USB_CDC        = 4'd11;
    localparam t_code ERR_MEMORY         = 4'd12;

    function automatic t_rgb mode_colour(input t_code mode);
        t_rgb c;
        unique case (mode) inside
            MODE_BOOT:                       c = C_RED;
            MODE_USB_WAIT, MODE_USB_OK:      c = C_CYAN;
            MODE_WIFI_CONN:                  c = C_ORANGE;
            MODE_HTTP_CHECK:                 c = C_YELLOW;
            MODE_MQTT_CONN, MODE_ONLINE:     c = C_GREEN;
            MODE_BLE_SCAN, MODE_BLE_CONN:    c = C_BLUE;
            default:                         c = C_OFF;
        endcase
        return c;
    endfunction

    function automatic t_ms mode_on(input t_code mode);
        t_ms t;
        unique case (mode) inside
            MODE_BOOT, MODE_USB_OK, MODE_ONLINE, MODE_BLE_CONN: t = MS_SOLID;
            MODE_USB_WAIT, MODE_MQTT_CONN:                      t = MS_BLINK_SLOW;
            MODE_WIFI_CONN, MODE_HTTP_CHECK, MODE_BLE_SCAN:     t = MS_BLINK_FAST;
            default:                                            t = MS_NONE;
        endcase
        return t;
    endfunction

    function automatic t_ms mode_off(input t_code mode);
        t_ms t;
        unique case (mode) inside
            MODE_USB_WAIT, MODE_MQTT_CONN:                  t = MS_BLINK_SLOW;
            MODE_WIFI_CONN, MODE_HTTP_CHECK, MODE_BLE_SCAN: t = MS_BLINK_FAST;
            default:                                        t = MS_NONE;
        endcase
        return t;
    endfunction

    function automatic t_rgb err_colour(input t_code err);
        t_rgb c;
        unique case (err) inside
            ERR_HTTP:                                         c = C_YELLOW;
            ERR_MQTT_INIT, ERR_MQTT_TRANSPORT, ERR_MQTT_CONNECT,
            ERR_MQTT_PUBLISH, ERR_USB_CDC:                    c = C_MAGENTA;
            ERR_WIFI:                                         c = C_ORANGE;
            ERR_BLE_SCAN, ERR_BLE_CONNECT, ERR_BLE_SEND:      c = C_BLUE;
            ERR_NVS_SAVE:                                     c = C_CYAN;
            ERR_MEMORY:                                       c = C_RED;
            default:                                          c = C_OFF;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] err_count(input t_code err);
        logic [2:0] n;
        unique case (err) inside
            ERR_HTTP, ERR_MQTT_INIT, ERR_MQTT_TRANSPORT, ERR_WIFI,
            ERR_BLE_SCAN, ERR_NVS_SAVE, ERR_USB_CDC:          n = 3'd3;
            ERR_MQTT_CONNECT, ERR_BLE_CONNECT:                n = 3'd2;
            ERR_MQTT_PUBLISH, ERR_BLE_SEND:                   n = 3'd1;
            ERR_MEMORY:                                       n = 3'd5;
            default:                                          n = 3'd0;
        endcase
        return n;
    endfunction

    // Length of the segment that the given stage is in.
    function automatic t_ms seg_length(input t_code err, input t_code mode,
                                       input t_stage stage);
        t_ms t;
        if (err != ERR_NONE) begin
            unique case (stage) inside
                STG_PFX_ON, STG_CODE_ON:   t = MS_PULSE_ON;
                STG_PFX_OFF, STG_CODE_OFF: t = MS_PULSE_OFF;
                STG_GAP:                   t = MS_GAP;
                default:                   t = (err == ERR_MEMORY) ? MS_MEM_TAIL : MS_TAIL;
            endcase
        end else if (stage == STG_OFF) begin
            t = mode_off(mode);
        end else begin
            t = (mode_on(mode) != MS_NONE) ? mode_on(mode) : MS_HOLD;
        end
        return t;
    endfunction

    // Colour shown when a new cycle starts.
    function automatic t_rgb start_colour(input t_code err, input t_code mode,
                                          input t_rgb cur);
        t_rgb c;
        if (err != ERR_NONE) begin
            c = C_RED;
        end else if (mode_on(mode) != MS_NONE) begin
            c = mode_colour(mode);
        end else begin
            c = cur;
        end
        return c;
    endfunction

endpackage

// ----- rtl/slbcs_in_if.sv -----
// Input channel of the sequencer: valid/ready with one event or tick per transfer.
interface slbcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] mode_code;
    logic [3:0] error_code;

    modport source (output valid, output opcode, output mode_code, output error_code,
                    input ready);
    modport sink   (input valid, input opcode, input mode_code, input error_code,
                    output ready);
endinterface

// ----- rtl/slbcs_out_if.sv -----
// Output channel of the sequencer: valid/ready with the LED colour per transfer.
interface slbcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       showing_error;

    modport source (output valid, output red, output green, output blue,
                    output showing_error, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input showing_error, output ready);
endinterface

// ----- rtl/slbcs_in_stage.sv -----
// Input register that captures one transfer and holds it until the core takes it.
module slbcs_in_stage
    import slbcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    slbcs_in_if.sink i_in,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_item.opcode     <= t_opcode'(i_in.opcode);
            r_item.mode_code  <= i_in.mode_code;
            r_item.error_code <= i_in.error_code;
        end
    end

endmodule

// ----- rtl/slbcs_core.sv -----
// Pattern state, next-state logic for one item, and the registered colour result.
`include "status_led_blink_code_sequencer_assert.svh"
module slbcs_core
    import slbcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    slbcs_out_if.source o_out
);

    logic       r_out_valid;
    t_rgb       r_out_colour;
    logic       r_out_err;

    t_code      r_req_mode,  n_req_mode;
    t_code      r_req_err,   n_req_err;
    t_code      r_cyc_mode,  n_cyc_mode;
    t_code      r_cyc_err,   n_cyc_err;
    t_stage     r_stage,     n_stage;
    logic [2:0] r_pulse,     n_pulse;
    t_ms        r_ms,        n_ms;
    t_rgb       r_colour,    n_colour;

    logic       w_fire;
    logic       w_show_err;

    assign o_take = !r_out_valid || o_out.ready;
    assign w_fire = o_take && i_valid;

    assign o_out.valid         = r_out_valid;
    assign o_out.red           = r_out_colour[23:16];
    assign o_out.green         = r_out_colour[15:8];
    assign o_out.blue          = r_out_colour[7:0];
    assign o_out.showing_error = r_out_err;

    always_comb begin
        n_req_mode = r_req_mode;
        n_req_err  = r_req_err;
        n_cyc_mode = r_cyc_mode;
        n_cyc_err  = r_cyc_err;
        n_stage    = r_stage;
        n_pulse    = r_pulse;
        n_ms       = r_ms;
        n_colour   = r_colour;
        unique case (i_item.opcode)
            OP_TICK: begin
                if (n_stage == STG_START || n_stage > STG_TAIL) begin
                    n_cyc_err  = r_req_err;
                    n_cyc_mode = r_req_mode;
                    n_pulse    = 3'd0;
                    n_ms       = MS_NONE;
                    n_stage    = STG_ON;
                    n_colour   = start_colour(r_req_err, r_req_mode, n_colour);
                end
                n_ms = n_ms + 10'd1;
                if (n_ms >= seg_length(n_cyc_err, n_cyc_mode, n_stage)) begin
                    n_ms = MS_NONE;
                    if (n_cyc_err != ERR_NONE) begin
                        case (n_stage) inside
                            STG_PFX_ON, STG_CODE_ON: begin
                                n_colour = C_OFF;
                                n_stage  = n_stage + 3'd1;
                            end
                            STG_PFX_OFF: begin
                                n_pulse = n_pulse + 3'd1;
                                if (n_pulse < PREFIX_PULSES) begin
                                    n_colour = C_RED;
                                    n_stage  = STG_PFX_ON;
                                end else begin
                                    n_pulse = 3'd0;
                                    n_stage = STG_GAP;
                                end
                            end
                            STG_GAP: begin
                                if (err_count(n_cyc_err) != 3'd0) begin
                                    n_colour = err_colour(n_cyc_err);
                                    n_stage  = STG_CODE_ON;
                                end else begin
                                    n_stage = STG_TAIL;
                                end
                            end
                            STG_CODE_OFF: begin
                                n_pulse = n_pulse + 3'd1;
                                if (n_pulse < err_count(n_cyc_err)) begin
                                    n_colour = err_colour(n_cyc_err);
                                    n_stage  = STG_CODE_ON;
                                end else begin
                                    n_stage = STG_TAIL;
                                end
                            end
                            default: begin
                                n_cyc_err  = r_req_err;
                                n_cyc_mode = r_req_mode;
                                n_pulse    = 3'd0;
                                n_stage    = STG_ON;
                                n_colour   = start_colour(r_req_err, r_req_mode, n_colour);
                            end
                        endcase
                    end else if (n_stage == STG_ON && mode_on(n_cyc_mode) != MS_NONE
                                 && mode_off(n_cyc_mode) != MS_NONE) begin
                        n_colour = C_OFF;
                        n_stage  = STG_OFF;
                    end else begin
                        n_cyc_err  = r_req_err;
                        n_cyc_mode = r_req_mode;
                        n_pulse    = 3'd0;
                        n_stage    = STG_ON;
                        n_colour   = start_colour(r_req_err, r_req_mode, n_colour);
                    end
                end
            end
            OP_SET_MODE: begin
                n_req_mode = i_item.mode_code;
                n_req_err  = ERR_NONE;
            end
            OP_SET_ERROR: begin
                n_req_err = i_item.error_code;
            end
            OP_CLEAR_ERROR: begin
                n_req_err = ERR_NONE;
            end
            default: begin
                n_req_err = r_req_err;
            end
        endcase
    end

    assign w_show_err = (n_stage >= STG_ON) && (n_stage <= STG_TAIL) && (n_cyc_err != ERR_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_req_mode  <= MODE_BOOT;
            r_req_err   <= ERR_NONE;
            r_cyc_mode  <= MODE_BOOT;
            r_cyc_err   <= ERR_NONE;
            r_stage     <= STG_START;
            r_pulse     <= 3'd0;
            r_ms        <= MS_NONE;
            r_colour    <= C_OFF;
        end else begin
            if (o_take) begin
                r_out_valid <= i_valid;
            end
            if (w_fire) begin
                r_req_mode <= n_req_mode;
                r_req_err  <= n_req_err;
                r_cyc_mode <= n_cyc_mode;
                r_cyc_err  <= n_cyc_err;
                r_stage    <= n_stage;
                r_pulse    <= n_pulse;
                r_ms       <= n_ms;
                r_colour   <= n_colour;
            end
        end
        if (w_fire) begin
            r_out_colour <= n_colour;
            r_out_err    <= w_show_err;
        end
    end

    `ASSERT_IMPLIES(a_stage_legal, i_clk, i_rst_n, 1'b1, r_stage <= STG_TAIL, "Stage code out of range.")
    `ASSERT_IMPLIES(a_ms_bound, i_clk, i_rst_n, 1'b1, r_ms < MS_MEM_TAIL, "Millisecond count ran past the longest segment.")
    `ASSERT_IMPLIES(a_prefix_count, i_clk, i_rst_n, (r_cyc_err != ERR_NONE) && (r_stage == STG_PFX_OFF), r_pulse < PREFIX_PULSES, "Prefix pulse count too high.")
    `ASSERT_IMPLIES(a_dark_gap, i_clk, i_rst_n, (r_cyc_err != ERR_NONE) && (r_stage == STG_GAP || r_stage == STG_TAIL), r_colour == C_OFF, "LED lit during an error gap.")
    `ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !w_fire, $stable(r_stage) && $stable(r_ms), "Pattern state moved without a transfer.")

endmodule

// ----- rtl/status_led_blink_code_sequencer.sv -----
// Status LED blink-code sequencer: ticks and events in, LED colour out.
// The input stage registers each transfer; the core takes it and loads one result per item
// into the result register when that register is empty or being read; it holds until taken.
// Throughput: one transfer per cycle on both channels while the output is not stalled.
// Reset (i_rst_n low, synchronous) clears the pattern state: LED dark, no cycle running,
// mode boot, no error; the first tick after reset starts the first cycle.
module status_led_blink_code_sequencer
    import slbcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    slbcs_in_if.sink    i_in,
    slbcs_out_if.source o_out
);

    logic  w_valid;
    logic  w_take;
    t_item w_item;

    slbcs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_item  (w_item)
    );

    slbcs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the status LED blink-code sequencer: predicts the LED colour after every transfer.
`timescale 1ns / 100ps

module tb_top;
    import slbcs_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       err;
    } t_led;

    class led_scoreboard;
        t_rgb       mode_rgb[16];
        t_ms        mode_on_ms[16];
        t_ms        mode_off_ms[16];
        t_rgb       err_rgb[16];
        logic [2:0] err_pulses[16];

        t_code      req_mode;
        t_code      req_err;
        t_code      cyc_mode;
        t_code      cyc_err;
        t_stage     stage;
        logic [2:0] pulses;
        t_ms        ms;
        t_rgb       colour;

        t_led led_q[$];
        int   fails;
        int   checked;
        int   err_shown;
        int   op_seen[4];

        function new();
            mode_rgb = '{C_RED, C_CYAN, C_CYAN, C_ORANGE, C_YELLOW, C_GREEN, C_GREEN,
                         C_BLUE, C_BLUE, C_OFF, C_OFF, C_OFF, C_OFF, C_OFF, C_OFF, C_OFF};
            mode_on_ms = '{MS_SOLID, MS_BLINK_SLOW, MS_SOLID, MS_BLINK_FAST, MS_BLINK_FAST,
                           MS_BLINK_SLOW, MS_SOLID, MS_BLINK_FAST, MS_SOLID, MS_NONE, MS_NONE,
                           MS_NONE, MS_NONE, MS_NONE, MS_NONE, MS_NONE};
            mode_off_ms = '{MS_NONE, MS_BLINK_SLOW, MS_NONE, MS_BLINK_FAST, MS_BLINK_FAST,
                            MS_BLINK_SLOW, MS_NONE, MS_BLINK_FAST, MS_NONE, MS_NONE, MS_NONE,
                            MS_NONE, MS_NONE, MS_NONE, MS_NONE, MS_NONE};
            err_rgb = '{C_OFF, C_YELLOW, C_MAGENTA, C_MAGENTA, C_MAGENTA, C_MAGENTA, C_ORANGE,
                        C_BLUE, C_BLUE, C_BLUE, C_CYAN, C_MAGENTA, C_RED, C_OFF, C_OFF, C_OFF};
            err_pulses = '{3'd0, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd3, 3'd3, 3'd2, 3'd1, 3'd3,
                           3'd3, 3'd5, 3'd0, 3'd0, 3'd0};
            req_mode = MODE_BOOT;
            req_err  = ERR_NONE;
            cyc_mode = MODE_BOOT;
            cyc_err  = ERR_NONE;
            stage    = STG_START;
            pulses   = '0;
            ms       = '0;
            colour   = C_OFF;
            fails    = 0;
            checked  = 0;
            err_shown = 0;
            op_seen  = '{0, 0, 0, 0};
        endfunction

        function void start_cycle();
            cyc_err  = req_err;
            cyc_mode = req_mode;
            pulses   = '0;
            ms       = '0;
            stage    = STG_ON;
            if (cyc_err != ERR_NONE) begin
                colour = C_RED;
            end else if (mode_on_ms[cyc_mode] != MS_NONE) begin
                colour = mode_rgb[cyc_mode];
            end
        endfunction

        function t_ms segment_ms();
            if (cyc_err != ERR_NONE) begin
                case (stage)
                    STG_PFX_ON, STG_CODE_ON:   return MS_PULSE_ON;
                    STG_PFX_OFF, STG_CODE_OFF: return MS_PULSE_OFF;
                    STG_GAP:                   return MS_GAP;
                    default:                   return (cyc_err == ERR_MEMORY) ? MS_MEM_TAIL
                                                                              : MS_TAIL;
                endcase
            end
            if (stage == STG_OFF) return mode_off_ms[cyc_mode];
            return (mode_on_ms[cyc_mode] != MS_NONE) ? mode_on_ms[cyc_mode] : MS_HOLD;
        endfunction

        function void advance();
            ms = '0;
            if (cyc_err != ERR_NONE) begin
                case (stage)
                    STG_PFX_ON, STG_CODE_ON: begin
                        colour = C_OFF;
                        stage  = stage + 3'd1;
                    end
                    STG_PFX_OFF: begin
                        pulses = pulses + 3'd1;
                        if (pulses < PREFIX_PULSES) begin
                            colour = C_RED;
                            stage  = STG_PFX_ON;
                        end else begin
                            pulses = '0;
                            stage  = STG_GAP;
                        end
                    end
                    STG_GAP: begin
                        if (err_pulses[cyc_err] != 3'd0) begin
                            colour = err_rgb[cyc_err];
                            stage  = STG_CODE_ON;
                        end else begin
                            stage = STG_TAIL;
                        end
                    end
                    STG_CODE_OFF: begin
                        pulses = pulses + 3'd1;
                        if (pulses < err_pulses[cyc_err]) begin
                            colour = err_rgb[cyc_err];
                            stage  = STG_CODE_ON;
                        end else begin
                            stage = STG_TAIL;
                        end
                    end
                    default: start_cycle();
                endcase
            end else if (stage == STG_ON && mode_on_ms[cyc_mode] != MS_NONE &&
                         mode_off_ms[cyc_mode] != MS_NONE) begin
                colour = C_OFF;
                stage  = STG_OFF;
            end else begin
                start_cycle();
            end
        endfunction

        function void note_input(t_item it);
            t_led exp;
            op_seen[it.opcode]++;
            case (it.opcode)
                OP_TICK: begin
                    if (stage == STG_START || stage > STG_TAIL) start_cycle();
                    ms = ms + 10'd1;
                    if (ms >= segment_ms()) advance();
                end
                OP_SET_MODE: begin
                    req_mode = it.mode_code;
                    req_err  = ERR_NONE;
                end
                OP_SET_ERROR: req_err = it.error_code;
                default:      req_err = ERR_NONE;
            endcase
            exp.red   = colour[23:16];
            exp.green = colour[15:8];
            exp.blue  = colour[7:0];
            exp.err   = (stage >= STG_ON && stage <= STG_TAIL && cyc_err != ERR_NONE);
            led_q.push_back(exp);
        endfunction

        function void check_result(t_led got);
            t_led exp;
            checked++;
            if (got.err) err_shown++;
            if (led_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: r=%02h g=%02h b=%02h err=%0b",
                             got.red, got.green, got.blue, got.err);
                return;
            end
            exp = led_q.pop_front();
            if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue ||
                got.err !== exp.err) begin
                fails++;
                if (fails <= 10)
                    $display("result %0d differs: expected r=%02h g=%02h b=%02h err=%0b, got r=%02h g=%02h b=%02h err=%0b",
                             checked, exp.red, exp.green, exp.blue, exp.err,
                             got.red, got.green, got.blue, got.err);
            end
        endfunction

        function int pending();
            return led_q.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1850;

    logic clk;
    logic rst_n;
    bit   calm;
    int   hold_req;
    int   items_sent;

    led_scoreboard sb;

    slbcs_in_if  in_ch();
    slbcs_out_if out_ch();

    status_led_blink_code_sequencer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_TICK;
        in_ch.mode_code  = '0;
        in_ch.error_code = '0;
        out_ch.ready     = 1'b0;
        calm             = 1'b0;
        hold_req         = 0;
        items_sent       = 0;
        sb               = new();
    end

    function automatic t_item mk(t_opcode op, t_code m, t_code e);
        t_item it;
        it.opcode     = op;
        it.mode_code  = m;
        it.error_code = e;
        return it;
    endfunction

    function automatic t_item pick_event();
        int r;
        t_opcode op;
        r = $urandom_range(0, 99);
        if (r < 55) op = OP_SET_MODE;
        else if (r < 75) op = OP_SET_ERROR;
        else op = OP_CLEAR_ERROR;
        return mk(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endfunction

    task automatic send_item(t_item it);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= it.opcode;
        in_ch.mode_code  <= it.mode_code;
        in_ch.error_code <= it.error_code;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic drain_pause();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 6);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.red, out_ch.green, out_ch.blue, out_ch.showing_error});
        end
    end

    initial begin
        int  burst;
        int  run;
        int  guard;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first tick after reset latches the boot cycle.
        send_item(mk(OP_TICK, 4'd0, 4'd0));
        send_item(mk(OP_SET_MODE, 4'd15, 4'd15));
        send_item(mk(OP_TICK, 4'd15, 4'd15));
        send_item(mk(OP_SET_ERROR, 4'd0, ERR_MEMORY));
        send_item(mk(OP_SET_ERROR, 4'd15, ERR_NONE));
        send_item(mk(OP_SET_ERROR, 4'd0, 4'd15));
        send_item(mk(OP_CLEAR_ERROR, 4'd15, 4'd15));
        send_item(mk(OP_SET_ERROR, 4'd0, ERR_HTTP));
        send_item(mk(OP_SET_MODE, MODE_BLE_CONN, 4'd0));
        send_item(mk(OP_SET_MODE, MODE_USB_WAIT, ERR_USB_CDC));
        send_item(mk(OP_SET_ERROR, 4'd9, ERR_MEMORY));
        send_item(mk(OP_CLEAR_ERROR, 4'd0, 4'd0));
        send_item(mk(OP_SET_MODE, 4'd9, 4'd0));
        send_item(mk(OP_SET_ERROR, 4'd6, 4'd13));
        repeat (8) send_item(mk(OP_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
        drain_pause();

        while (items_sent < RANDOM_ITEMS + 22) begin
            calm = (items_sent > RANDOM_ITEMS - 280);
            if (!held && items_sent > 500) begin
                hold_req = 80;
                held     = 1'b1;
            end
            if (!paused && items_sent > 1100) begin
                drain_pause();
                paused = 1'b1;
            end
            burst = $urandom_range(0, 3);
            repeat (burst) send_item(pick_event());
            run = $urandom_range(10, 250);
            repeat (run)
                send_item(mk(OP_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
            sb.fails += sb.pending();
        end

        $display("Sent %0d ticks, %0d mode, %0d error and %0d clear transfers.",
                 sb.op_seen[OP_TICK], sb.op_seen[OP_SET_MODE], sb.op_seen[OP_SET_ERROR],
                 sb.op_seen[OP_CLEAR_ERROR]);
        $display("Checked %0d results, %0d of them during an error pattern; %0d failures.",
                 sb.checked, sb.err_shown, sb.fails);
        if (sb.fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run did not finish in time.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- status_led_blink_code_sequencer.f -----
+incdir+rtl
rtl/slbcs_pkg.sv
rtl/slbcs_in_if.sv
rtl/slbcs_out_if.sv
rtl/slbcs_in_stage.sv
rtl/slbcs_core.sv
rtl/status_led_blink_code_sequencer.sv
bench/tb_top.sv
